[design/cbt_pkg.sv]
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types, codes and byte operations of the context byte transform.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

   // Item kinds on the request channel
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREV_BITS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OLDER_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLEX_MODE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHARED_OP  = 2'd3;
   localparam int unsigned CSR_DATA_W = 4;

   // Field widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned OP_W       = 4;
   localparam int unsigned BITS_W     = 3;
   localparam int unsigned GRP_IDX_W  = 6;
   localparam int unsigned GRP_SPAN   = 64;

   // GF(2^8) reduction constant (0x11B without the top bit)
   localparam logic [7:0] GF_POLY = 8'h1B;

   typedef enum logic [OP_W-1:0] {
      OP_ADD        = 4'd0,
      OP_XOR        = 4'd1,
      OP_MUL_ODD    = 4'd2,
      OP_LO_ADD     = 4'd3,
      OP_SWAP_XOR   = 4'd4,
      OP_GF_MUL     = 4'd5,
      OP_ROTL       = 4'd6,
      OP_HI_ADD     = 4'd7,
      OP_ADD_GRAY   = 4'd8,
      OP_HI_FOLD    = 4'd9,
      OP_LO_SUB     = 4'd10,
      OP_HI_SUB     = 4'd11,
      OP_SUB        = 4'd12,
      OP_LO_XOR     = 4'd13,
      OP_HI_XOR     = 4'd14,
      OP_ROTR       = 4'd15
   } op_type;

   // GF(2^8) multiply modulo x^8+x^4+x^3+x+1, shift-and-add over eight bits
   function automatic logic [7:0] gf_times(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] acc;
      logic [7:0] a;
      acc = 8'h00;
      a   = x;
      for (int k = 0; k < 8; k++) begin
         if (y[k]) acc = acc ^ a;
         a = a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
      end
      return acc;
   endfunction

   // One of the sixteen reversible byte operations
   function automatic logic [7:0] byte_op(input logic [7:0] v, input logic [7:0] a,
                                         input op_type code);
      logic [15:0] prod;
      logic [7:0]  gf_b;
      logic [2:0]  s;
      logic [7:0]  w;
      logic [7:0]  r;
      prod = {8'd0, v} * {8'd0, (a | 8'h01)};
      gf_b = (a < 8'd2) ? 8'd2 : a;
      s    = (a[2:0] == 3'd0) ? 3'd1 : a[2:0];
      w    = v + a;
      case (code)
         OP_ADD:      r = v + a;
         OP_XOR:      r = v ^ a;
         OP_MUL_ODD:  r = prod[7:0];
         OP_LO_ADD:   r = {v[7:4], v[3:0] + a[3:0]};
         OP_SWAP_XOR: r = {v[3:0], v[7:4]} ^ a;
         OP_GF_MUL:   r = gf_times(v, gf_b);
         OP_ROTL:     r = 8'(({v, v} << s) >> 8);
         OP_HI_ADD:   r = {v[7:4] + a[3:0], v[3:0]};
         OP_ADD_GRAY: r = w ^ {1'b0, w[7:1]};
         OP_HI_FOLD:  r = {v[7:4] ^ v[3:0] ^ a[3:0], v[3:0]};
         OP_LO_SUB:   r = {v[7:4], a[3:0] - v[3:0]};
         OP_HI_SUB:   r = {a[3:0] - v[7:4], v[3:0]};
         OP_SUB:      r = a - v;
         OP_LO_XOR:   r = {v[7:4], v[3:0] ^ a[3:0]};
         OP_HI_XOR:   r = {v[7:4] ^ a[3:0], v[3:0]};
         default:     r = 8'({v, v} >> s);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[design/context_byte_transform_unit.sv]
// ----------------------------------------------------------------------------
// context_byte_transform_unit
// Byte-stream transform conditioned on the two previous original bytes.
//
// Takes one item per cycle while the result channel is not stalled, data bytes
// and table writes alike. A data byte's result goes through the synchronous
// read of the group table, registered with the byte, and then through the byte
// operation into the output register. The group index comes from history
// registers updated at acceptance, so back-to-back bytes never wait on each
// other, and a table write lands in the memory before any later byte reads it.
// Table writes give no result. The group table holds amount and operation per
// group and has no reset; reading a group that was never written gives an undefined byte.
// The first two bytes of each block, and of the stream after reset, pass
// through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module context_byte_transform_unit #(
   parameter int unsigned GROUPS = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_kind,
   input  wire logic [cbt_pkg::BYTE_W-1:0]       req_data_byte,
   input  wire logic                             req_start_of_block,
   input  wire logic [cbt_pkg::GRP_IDX_W-1:0]    req_entry_index,
   input  wire logic [cbt_pkg::BYTE_W-1:0]       req_entry_amount,
   input  wire logic [cbt_pkg::OP_W-1:0]         req_entry_operation,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [cbt_pkg::BYTE_W-1:0]            rsp_out_byte,
   // configuration port
   input  wire logic                             csr_write_enable,
   input  wire logic [cbt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [cbt_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   import cbt_pkg::*;

   localparam int unsigned IDX_W   = $clog2(GROUPS);
   localparam int unsigned ENTRY_W = OP_W + BYTE_W;

   // configuration
   logic [BITS_W-1:0] prev_bits_ff;
   logic [BITS_W-1:0] older_bits_ff;
   logic              flex_ff;
   logic [OP_W-1:0]   shared_op_ff;

   // stream history
   logic [BYTE_W-1:0] last_ff, last_in;
   logic [BYTE_W-1:0] older_ff, older_in;
   logic [1:0]        pos_ff, pos_in;

   // table read stage
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_pass_ff;
   logic [ENTRY_W-1:0] rd_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;

   logic [ENTRY_W-1:0] tab_mem [GROUPS];

   logic              accept;
   logic              accept_data;
   logic              accept_write;
   logic              advance;
   logic              pass;
   logic [1:0]        pos_eff;
   logic [15:0]       hi_part;
   logic [15:0]       lo_part;
   logic [15:0]       grp_raw;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  grp_mod [GRP_SPAN];
   logic              wr_in_range;
   op_type            code;
   logic [BYTE_W-1:0] xf_byte;

   // handshake
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign accept_data  = accept && (req_kind == KIND_DATA);
   assign accept_write = accept && (req_kind == KIND_WRITE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   // constant table: group index folded into the table depth
   for (genvar g = 0; g < GRP_SPAN; g++) begin : g_mod
      assign grp_mod[g] = IDX_W'(g % GROUPS);
   end

   // block position and passthrough decision
   always_comb begin
      pos_eff = req_start_of_block ? 2'd0 : pos_ff;
      pass    = (pos_eff < 2'd2);
      pos_in  = pass ? pos_eff + 2'd1 : pos_eff;
      last_in  = req_data_byte;
      older_in = last_ff;
   end

   // group index from the top bits of the two previous bytes
   always_comb begin
      hi_part = 16'({8'd0, last_ff} >> (4'd8 - {1'b0, prev_bits_ff}));
      lo_part = 16'({8'd0, older_ff} >> (4'd8 - {1'b0, older_bits_ff}));
      grp_raw = (hi_part << older_bits_ff) | lo_part;
      rd_addr = grp_mod[grp_raw[GRP_IDX_W-1:0]];
   end

   assign wr_in_range = ({1'b0, req_entry_index} < (GRP_IDX_W+1)'(GROUPS));

   // group table: write on a table item, read on a data byte
   always_ff @(posedge clock) begin
      if (accept_write && wr_in_range) begin
         tab_mem[req_entry_index[IDX_W-1:0]] <= {req_entry_operation, req_entry_amount};
      end
      if (accept_data) begin
         rd_ff <= tab_mem[rd_addr];
      end
   end

   // byte operation with the entry's amount and the entry's or the shared operation
   always_comb begin
      code    = flex_ff ? op_type'(rd_ff[ENTRY_W-1:BYTE_W]) : op_type'(shared_op_ff);
      xf_byte = s1_pass_ff ? s1_byte_ff : byte_op(s1_byte_ff, rd_ff[BYTE_W-1:0], code);
   end

   always_comb begin
      s1_valid_in  = accept_data ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_bits_ff  <= 3'd1;
         older_bits_ff <= 3'd1;
         flex_ff       <= 1'b0;
         shared_op_ff  <= OP_ADD;
         last_ff       <= '0;
         older_ff      <= '0;
         pos_ff        <= 2'd0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_PREV_BITS:  prev_bits_ff  <= csr_write_data[BITS_W-1:0];
               CSR_OLDER_BITS: older_bits_ff <= csr_write_data[BITS_W-1:0];
               CSR_FLEX_MODE:  flex_ff       <= csr_write_data[0];
               CSR_SHARED_OP:  shared_op_ff  <= csr_write_data[OP_W-1:0];
               default:        ;
            endcase
         end
         if (accept_data) begin
            last_ff  <= last_in;
            older_ff <= older_in;
            pos_ff   <= pos_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept_data) begin
         s1_byte_ff <= req_data_byte;
         s1_pass_ff <= pass;
      end
      if (advance && s1_valid_ff) begin
         rsp_byte_ff <= xf_byte;
      end
   end

`ifndef SYNTHESIS
   // a data byte always reaches the table read stage
   assert property (@(posedge clock) disable iff (reset)
      accept_data |=> s1_valid_ff)
      else $error("data item lost before table read");

   // a held result is never overwritten by the next stage
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("table read stage accepted while blocked");

   // block position saturates at two
   assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("block position out of range");

   // a table write gives no result
   assert property (@(posedge clock) disable iff (reset)
      (accept_write && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("table write produced a result");
`endif

endmodule

`default_nettype wire
